@@ src/ifpp_pkg.sv @@
package ifpp_pkg;

    localparam int unsigned MAX_BURST_BYTES_DEF = 2080;
    localparam int unsigned PKT_LEN = 16;
    localparam int unsigned POS_W = 4;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned HOLD_BYTES = PKT_LEN - 2;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned SAMPLE_W = 120;
    localparam int unsigned STATUS_W = 2;

    localparam int unsigned HDR_EMPTY_BIT = 7;
    localparam int unsigned HDR_ACCEL_BIT = 6;
    localparam int unsigned HDR_GYRO_BIT = 5;

    typedef enum logic [1:0] {
        OP_STORE      = 2'd0,
        OP_SAMPLE     = 2'd1,
        OP_STOP_EMPTY = 2'd2,
        OP_STOP_BAD   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SAMPLE     = 2'd0,
        ST_STOP_EMPTY = 2'd1,
        ST_STOP_BAD   = 2'd2
    } status_t;

    typedef struct packed {
        op_t               op;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } entry_t;

endpackage

@@ src/ifpp_front.sv @@
module ifpp_front #(
    parameter int unsigned MAX_BURST_BYTES = ifpp_pkg::MAX_BURST_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         fire,
    input  logic [ifpp_pkg::BYTE_W-1:0]  data_byte,
    input  logic                         burst_start,
    output logic                         push,
    output ifpp_pkg::entry_t             push_entry
);

    localparam int unsigned CNT_W = $clog2(MAX_BURST_BYTES + 1);

    logic [ifpp_pkg::POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [CNT_W-1:0]           cnt_reg, cnt_next, cnt_eff;
    logic                       halted_reg, halted_next, halted_eff;

    always_comb
    begin
        pos_eff     = burst_start ? '0 : pos_reg;
        cnt_eff     = burst_start ? '0 : cnt_reg;
        halted_eff  = burst_start ? 1'b0 : halted_reg;
        pos_next    = pos_eff;
        cnt_next    = cnt_eff;
        halted_next = halted_eff;
        push        = 1'b0;
        push_entry.op   = ifpp_pkg::OP_STORE;
        push_entry.pos  = pos_eff;
        push_entry.data = data_byte;
        if (!halted_eff && (cnt_eff < CNT_W'(MAX_BURST_BYTES)))
        begin
            cnt_next = cnt_eff + CNT_W'(1);
            if (pos_eff == '0)
            begin
                if (data_byte[ifpp_pkg::HDR_EMPTY_BIT])
                begin
                    push          = 1'b1;
                    push_entry.op = ifpp_pkg::OP_STOP_EMPTY;
                    halted_next   = 1'b1;
                end
                else if (!data_byte[ifpp_pkg::HDR_ACCEL_BIT] ||
                         !data_byte[ifpp_pkg::HDR_GYRO_BIT])
                begin
                    push          = 1'b1;
                    push_entry.op = ifpp_pkg::OP_STOP_BAD;
                    halted_next   = 1'b1;
                end
                else
                begin
                    pos_next = ifpp_pkg::POS_W'(1);
                end
            end
            else if (pos_eff < ifpp_pkg::POS_W'(ifpp_pkg::PKT_LEN - 1))
            begin
                push     = 1'b1;
                pos_next = pos_eff + ifpp_pkg::POS_W'(1);
            end
            else
            begin
                push          = 1'b1;
                push_entry.op = ifpp_pkg::OP_SAMPLE;
                pos_next      = '0;
            end
        end
        push = push && fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            cnt_reg    <= '0;
            halted_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            halted_reg <= halted_next;
        end
    end

endmodule

@@ src/ifpp_queue.sv @@
module ifpp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ifpp_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output ifpp_pkg::entry_t  head_entry
);

    ifpp_pkg::entry_t               slot_reg [ifpp_pkg::QUEUE_DEPTH];
    logic [ifpp_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [ifpp_pkg::QPTR_W:0]      count_reg, count_next;

    assign full       = (count_reg == (ifpp_pkg::QPTR_W + 1)'(ifpp_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && head_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ src/ifpp_back.sv @@
module ifpp_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            head_valid,
    input  ifpp_pkg::entry_t                head_entry,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ifpp_pkg::SAMPLE_W-1:0]   out_data,
    output logic [ifpp_pkg::STATUS_W-1:0]   out_status
);

    logic [ifpp_pkg::BYTE_W-1:0]   pb_reg [ifpp_pkg::HOLD_BYTES];
    logic                          out_valid_reg, out_valid_next;
    logic [ifpp_pkg::SAMPLE_W-1:0] out_data_reg, out_data_next;
    ifpp_pkg::status_t             out_status_reg, out_status_next;
    logic                          is_store, emit;
    logic [ifpp_pkg::POS_W-1:0]    wr_idx;

    assign is_store = (head_entry.op == ifpp_pkg::OP_STORE);
    assign pop      = head_valid && (is_store || !out_valid_reg || out_ready);
    assign emit     = pop && !is_store;
    assign wr_idx   = head_entry.pos - ifpp_pkg::POS_W'(1);

    always_comb
    begin
        out_data_next   = '0;
        out_status_next = ifpp_pkg::ST_SAMPLE;
        unique case (head_entry.op)
            ifpp_pkg::OP_SAMPLE:
            begin
                out_data_next = {pb_reg[13], head_entry.data, pb_reg[12],
                                 pb_reg[10], pb_reg[11], pb_reg[8], pb_reg[9],
                                 pb_reg[6], pb_reg[7], pb_reg[4], pb_reg[5],
                                 pb_reg[2], pb_reg[3], pb_reg[0], pb_reg[1]};
            end
            ifpp_pkg::OP_STOP_EMPTY: out_status_next = ifpp_pkg::ST_STOP_EMPTY;
            ifpp_pkg::OP_STOP_BAD:   out_status_next = ifpp_pkg::ST_STOP_BAD;
            default:                 out_status_next = ifpp_pkg::ST_SAMPLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && is_store)
        begin
            pb_reg[wr_idx] <= head_entry.data;
        end
        if (emit)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;

endmodule

@@ src/imu_fifo_packet_parser_core.sv @@
// Channel   Dir  Handshake          Payload
// s_axis    in   s_tvalid/s_tready  s_tdata: data_byte; s_tuser: burst_start
// m_axis    out  m_tvalid/m_tready  m_tdata: sample fields; m_tuser: status
//
// One word is taken every cycle while the four-entry queue between the byte
// classifier and the packet assembler has room. With an empty queue the result that a
// word completes is written into the queue and then into the output register, where it
// holds until taken; the assembler keeps draining buffered bytes until the next result
// reaches the head of the queue. Reset is asynchronous and clears the packet position,
// burst count, halt flag, queue and output valid.
module imu_fifo_packet_parser_core #(
    parameter int unsigned MAX_BURST_BYTES = ifpp_pkg::MAX_BURST_BYTES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // data_byte
    input  logic [0:0]                      s_tuser,  // burst_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temperature, timestamp
    output logic [ifpp_pkg::SAMPLE_W-1:0]   m_tdata,
    output logic [ifpp_pkg::STATUS_W-1:0]   m_tuser   // status
);

    logic             fire, push, pop, q_full, head_valid;
    ifpp_pkg::entry_t push_entry, head_entry;

    assign s_tready = !q_full;
    assign fire     = s_tvalid && s_tready;

    ifpp_front #(
        .MAX_BURST_BYTES (MAX_BURST_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .data_byte   (s_tdata),
        .burst_start (s_tuser[0]),
        .push        (push),
        .push_entry  (push_entry)
    );

    ifpp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    ifpp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (m_tdata),
        .out_status (m_tuser)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("queue written while full");

    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ifpp_pkg::ST_SAMPLE)) |-> (m_tdata == '0))
        else $error("stop result carries nonzero data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tuser == ifpp_pkg::ST_SAMPLE) ||
                      (m_tuser == ifpp_pkg::ST_STOP_EMPTY) ||
                      (m_tuser == ifpp_pkg::ST_STOP_BAD)))
        else $error("undefined status code");
`endif

endmodule
